>>> design/lswf_pkg.sv
// Shared constants and types for the local statistics Wiener filter.
package lswf_pkg;
    localparam int MAX_HALF_WIDTH_DEF = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int NOISE_BITS = 31;
    localparam int CFG_DATA_BITS = 31;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NOISE = 1'b1;
    localparam int DIV_BITS = 64;

    // handshake between sequencer and divider
    typedef struct packed {
        logic start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [DIV_BITS-1:0] quo;
        logic [DIV_BITS-1:0] rem;
    } div_rsp_t;
endpackage

>>> design/lswf_div.sv
// Restoring divider, one quotient bit per cycle.
module lswf_div
    import lswf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CB = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] quo_reg, rem_reg, den_reg;
    logic [CB-1:0]       cnt_reg;
    logic                busy_reg, done_reg;
    logic [DIV_BITS:0]   trial;

    assign trial = {rem_reg, quo_reg[DIV_BITS-1]} - {1'b0, den_reg};

    // step one bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(DIV_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CB'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_BITS])
            begin
                rem_reg <= trial[DIV_BITS-1:0];
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DIV_BITS-2:0], quo_reg[DIV_BITS-1]};
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;
endmodule

>>> design/local_stats_wiener_filter.sv
// Local statistics Wiener filter: a window ring, a sequencer and a shared divider.
//
// Usage: samples enter on sample/last_in under valid_in/stall_in; filtered samples
// leave on filtered/last_out under valid_out/stall_out. Configuration is written
// through cfg_we/cfg_index/cfg_data while idle: index 0 half width, index 1 noise.
// Each output is computed over a window of up to 2K+1 samples; outputs lag the input
// by K samples and the last input flushes every pending output, up to 16 of them.
// Per input the block writes the ring and then checks and finishes; per output it
// takes a check step, walks the window through the ring read port (n samples, n up
// to 2K+1), takes four multiply steps, starts the divider, waits on the bit-serial
// divider and then writes the output register. The block takes no item while busy.
// A finished result sits in the output register; while stall_out is high and that
// result is still held, the sequencer waits and no further item is taken.
// Reset clears the slot, pending and output counters and puts K = 1, noise = 0;
// the ring holds no valid data and needs no clearing: only written entries are read.
module local_stats_wiener_filter
    import lswf_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    output logic                        stall_in,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                        last_in,
    output logic                        valid_out,
    input  logic                        stall_out,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                        last_out,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data
);
    localparam int DEPTH = 2 * MAX_HALF_WIDTH + 2;
    localparam int AB = $clog2(DEPTH);
    localparam int KB = $clog2(MAX_HALF_WIDTH + 1);
    localparam int PB = $clog2(DEPTH + 1);
    localparam int NB = $clog2(2 * MAX_HALF_WIDTH + 2);
    localparam int SB = SAMPLE_BITS + NB + 1;
    localparam int QB = 2 * SAMPLE_BITS + NB;
    localparam int OB = 6;
    localparam logic [OB-1:0] CSAT = 6'd63;

    localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_ACC = 4'd2,
        S_M1 = 4'd3, S_M2 = 4'd4, S_M3 = 4'd5, S_DIV = 4'd6, S_WAIT = 4'd7,
        S_OUT = 4'd8, S_FIN = 4'd9, S_GO = 4'd10;

    logic [3:0]  state_reg;
    logic [3:0]  hw_reg;
    logic [NOISE_BITS-1:0] noise_reg;
    logic signed [SAMPLE_BITS-1:0] ring [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic [AB-1:0] wslot_reg, rptr_reg, oslot_reg;
    logic [PB-1:0] pend_reg;
    logic [OB-1:0] nout_reg;
    logic          last_reg, flush_reg;
    logic [NB-1:0] n_reg, d_reg;
    logic signed [SB-1:0] s_reg;
    logic [QB-1:0] q_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [DIV_BITS-1:0] den_reg, num_reg;
    logic signed [SB+1:0] diff_reg;
    logic [4:0] emit_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic outlast_reg, outv_reg;
    div_req_t dreq;
    div_rsp_t drsp;

    logic [KB-1:0] keff;
    logic [NB-1:0] left, right;
    logic [AB:0]   start_sum;
    logic [AB-1:0] oslot_c;
    logic [SB-1:0] sabs;
    logic [SB+1:0] dmag;
    logic [DIV_BITS-1:0] q_rnd;
    logic signed [SAMPLE_BITS+1:0] y;
    logic          more;

    // effective half width, clamped
    always_comb
    begin
        if (hw_reg == 4'd0)
            keff = KB'(1);
        else if (32'(hw_reg) > MAX_HALF_WIDTH)
            keff = KB'(MAX_HALF_WIDTH);
        else
            keff = KB'(hw_reg);
    end

    assign left  = (32'(nout_reg) < 32'(keff)) ? NB'(nout_reg) : NB'(keff);
    assign right = (32'(pend_reg) - 1 < 32'(keff)) ? NB'(pend_reg - 1'b1) : NB'(keff);
    assign start_sum = (AB+1)'(wslot_reg) + (AB+1)'(DEPTH) - (AB+1)'(pend_reg);
    assign oslot_c = (start_sum >= (AB+1)'(DEPTH)) ? AB'(start_sum - (AB+1)'(DEPTH))
                                                   : AB'(start_sum);
    assign more = (32'(pend_reg) > 32'(keff)) || (flush_reg && pend_reg != '0);
    assign sabs = s_reg[SB-1] ? SB'(-s_reg) : SB'(s_reg);
    assign dmag = diff_reg[SB+1] ? (SB+2)'(-diff_reg) : (SB+2)'(diff_reg);
    assign q_rnd = drsp.quo + ((drsp.rem >= den_reg - drsp.rem) ? 64'd1 : 64'd0);

    // apply correction and saturate
    always_comb
    begin
        logic [SAMPLE_BITS:0] qc;
        qc = (q_rnd > (64'd1 << SAMPLE_BITS)) ? (SAMPLE_BITS+1)'(1 << SAMPLE_BITS)
                                              : (SAMPLE_BITS+1)'(q_rnd);
        if (diff_reg < 0)
            y = (SAMPLE_BITS+2)'(x_reg) + (SAMPLE_BITS+2)'(qc);
        else
            y = (SAMPLE_BITS+2)'(x_reg) - (SAMPLE_BITS+2)'(qc);
    end

    assign stall_in = (state_reg != S_IDLE);
    // start the divider once the numerator is complete
    assign dreq.start = (state_reg == S_GO);
    assign dreq.num = num_reg;
    assign dreq.den = den_reg;

    lswf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // ring write and registered read
    always_ff @(posedge clk)
    begin
        if (valid_in && !stall_in)
            ring[wslot_reg] <= sample;
        rd_reg <= ring[rptr_reg];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg    <= 4'd1;
            noise_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_HALF_WIDTH)
                hw_reg <= cfg_data[3:0];
            else if (cfg_index == REG_NOISE)
                noise_reg <= cfg_data[NOISE_BITS-1:0];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wslot_reg <= '0;
            pend_reg  <= '0;
            nout_reg  <= '0;
            flush_reg <= 1'b0;
            outv_reg  <= 1'b0;
            emit_reg  <= '0;
        end
        else
        begin
            if (outv_reg && !stall_out && state_reg != S_OUT)
                outv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (valid_in)
                    begin
                        wslot_reg <= (32'(wslot_reg) == DEPTH - 1) ? '0 : wslot_reg + 1'b1;
                        if (32'(pend_reg) < DEPTH)
                            pend_reg <= pend_reg + 1'b1;
                        flush_reg <= last_in;
                        emit_reg  <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (more && emit_reg < 5'd16)
                    begin
                        n_reg     <= left + right + 1'b1;
                        oslot_reg <= oslot_c;
                        rptr_reg  <= (oslot_c >= AB'(left)) ? oslot_c - AB'(left)
                                     : AB'((AB+1)'(oslot_c) + (AB+1)'(DEPTH) - (AB+1)'(left));
                        d_reg     <= '0;
                        s_reg     <= '0;
                        q_reg     <= '0;
                        last_reg  <= flush_reg && pend_reg == PB'(1);
                        state_reg <= S_ACC;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_ACC:
                begin
                    // read issued at d, data arrives in the next cycle
                    if (d_reg != '0)
                    begin
                        s_reg <= s_reg + SB'(rd_reg);
                        q_reg <= q_reg + QB'($unsigned(32'(rd_reg) * 32'(rd_reg)));
                        if (rptr_reg == oslot_reg + 1'b1 ||
                            (oslot_reg == AB'(DEPTH - 1) && rptr_reg == '0))
                            x_reg <= rd_reg;
                    end
                    if (d_reg == n_reg)
                        state_reg <= S_M1;
                    else
                    begin
                        d_reg    <= d_reg + 1'b1;
                        rptr_reg <= (32'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + 1'b1;
                    end
                end
                S_M1:
                begin
                    if (n_reg == NB'(1))
                        x_reg <= s_reg[SAMPLE_BITS-1:0];
                    den_reg  <= DIV_BITS'(q_reg) * DIV_BITS'(n_reg);
                    num_reg  <= DIV_BITS'(sabs) * DIV_BITS'(sabs);
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    den_reg  <= (den_reg - num_reg < DIV_BITS'(n_reg) * DIV_BITS'(n_reg))
                                ? DIV_BITS'(n_reg) * DIV_BITS'(n_reg) : den_reg - num_reg;
                    diff_reg <= (SB+2)'(x_reg) * (SB+2)'($signed({1'b0, n_reg})) - (SB+2)'(s_reg);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    num_reg  <= DIV_BITS'(noise_reg) * DIV_BITS'(dmag);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    num_reg  <= num_reg * DIV_BITS'(n_reg);
                    state_reg <= S_GO;
                end
                S_GO:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (drsp.done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!outv_reg || !stall_out)
                    begin
                        outv_reg <= 1'b1;
                        if (y > (SAMPLE_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1))
                            out_reg <= SAMPLE_BITS'((1 << (SAMPLE_BITS-1)) - 1);
                        else if (y < -(SAMPLE_BITS+2)'(1 << (SAMPLE_BITS-1)))
                            out_reg <= SAMPLE_BITS'(1 << (SAMPLE_BITS-1));
                        else
                            out_reg <= y[SAMPLE_BITS-1:0];
                        outlast_reg <= last_reg;
                        pend_reg <= pend_reg - 1'b1;
                        if (nout_reg < CSAT)
                            nout_reg <= nout_reg + 1'b1;
                        emit_reg <= emit_reg + 1'b1;
                        state_reg <= S_CHECK;
                    end
                end
                S_FIN:
                begin
                    if (flush_reg)
                    begin
                        pend_reg <= '0;
                        nout_reg <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign valid_out = outv_reg;
    assign filtered  = out_reg;
    assign last_out  = outlast_reg;

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> stall_in) else $error("accept while busy");
    a_pend: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pend_reg) <= DEPTH) else $error("pending overflow");
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == S_WAIT) else $error("stray divider result");
endmodule

>>> sim/testbench.sv
// Self-checking testbench for the local statistics Wiener filter.
`timescale 1ns / 1ps

module testbench;
    import lswf_pkg::*;

    localparam int RING = 2 * MAX_HALF_WIDTH_DEF + 2;
    localparam int SETTLE_CYCLES = 250;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last;
    } filtered_item_t;

    // Window predictor and store of expected filtered items
    class filter_scoreboard;
        logic signed [SAMPLE_BITS-1:0] ring[RING];
        int unsigned wr_slot;
        int unsigned waiting;
        int unsigned out_index;
        logic [3:0]  k_reg;
        logic [NOISE_BITS-1:0] noise_reg;
        filtered_item_t expected_q[$];
        int mismatches;

        function new();
            wr_slot = 0;
            waiting = 0;
            out_index = 0;
            k_reg = 4'd1;
            noise_reg = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_HALF_WIDTH)
                k_reg = data[3:0];
            else
                noise_reg = data[NOISE_BITS-1:0];
        endfunction

        function int unsigned window_k();
            int unsigned k;
            k = k_reg;
            if (k < 1) k = 1;
            if (k > MAX_HALF_WIDTH_DEF) k = MAX_HALF_WIDTH_DEF;
            return k;
        endfunction

        // Filter the oldest waiting sample and queue its result
        function void answer_oldest(bit is_last);
            int unsigned kk, oslot, left, right, n, d, slot;
            longint signed sum, x, diff, y;
            longint unsigned sq, m, sabs, den, nn, num, q, r;
            filtered_item_t item;
            kk = window_k();
            oslot = (wr_slot + RING - (waiting % RING)) % RING;
            left = (out_index < kk) ? out_index : kk;
            right = ((waiting - 1) < kk) ? (waiting - 1) : kk;
            n = left + right + 1;
            sum = 0;
            sq = 0;
            for (d = 0; d < n; d++)
            begin
                slot = (oslot + RING - left + d) % RING;
                x = ring[slot];
                m = (x < 0) ? -x : x;
                sum += x;
                sq += m * m;
            end
            x = ring[oslot];
            sabs = (sum < 0) ? -sum : sum;
            den = sq * n - sabs * sabs;
            nn = n * n;
            if (den < nn) den = nn;
            diff = x * n - sum;
            num = longint'(noise_reg) * ((diff < 0) ? -diff : diff) * n;
            q = num / den;
            r = num % den;
            if (r >= den - r) q++;
            if (q > 65536) q = 65536;
            y = (diff < 0) ? x + longint'(q) : x - longint'(q);
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            item.value = y[SAMPLE_BITS-1:0];
            item.last = is_last;
            expected_q.push_back(item);
            waiting--;
            if (out_index < 63) out_index++;
        endfunction

        function void note_input(logic signed [SAMPLE_BITS-1:0] s, logic l);
            int k;
            k = 0;
            ring[wr_slot] = s;
            wr_slot = (wr_slot + 1) % RING;
            if (waiting < RING) waiting++;
            while (k < 16 && waiting > window_k())
            begin
                answer_oldest(l && waiting == 1);
                k++;
            end
            if (l)
            begin
                while (k < 16 && waiting > 0)
                begin
                    answer_oldest(waiting == 1);
                    k++;
                end
                waiting = 0;
                out_index = 0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check(logic signed [SAMPLE_BITS-1:0] f, logic l);
            filtered_item_t exp_item;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item filtered=%0d last=%0b", f, l));
                return;
            end
            exp_item = expected_q.pop_front();
            if (f !== exp_item.value)
                report_mismatch($sformatf("filtered %0d, want %0d", f, exp_item.value));
            if (l !== exp_item.last)
                report_mismatch($sformatf("last_out %0b, want %0b", l, exp_item.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic valid_in = 1'b0;
    logic stall_in;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic last_in = 1'b0;
    logic valid_out;
    logic stall_out = 1'b0;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic last_out;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    filter_scoreboard sb = new();
    int send_idle_pct = 16;
    int recv_idle_pct = 77;
    int hold_request = 0;
    int items_sent = 0;

    local_stats_wiener_filter dut (.*);

    always #10 clk = ~clk;

    // Stall the result side at random, or for a long stretch on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                stall_out <= 1'b1;
                hold_left--;
            end
            else
                stall_out <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n && valid_out && !stall_out)
            sb.check(filtered, last_out);
    end

    task automatic send_item(logic signed [SAMPLE_BITS-1:0] s, logic l);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            valid_in <= 1'b0;
            @(negedge clk);
        end
        valid_in <= 1'b1;
        sample <= s;
        last_in <= l;
        do @(posedge clk); while (stall_in);
        sb.note_input(s, l);
        items_sent++;
    endtask

    // Drain outstanding results, then let the divider settle
    task automatic wait_idle();
        @(negedge clk);
        valid_in <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic configure(int k, logic [CFG_DATA_BITS-1:0] noise);
        wait_idle();
        write_reg(REG_HALF_WIDTH, CFG_DATA_BITS'(k));
        write_reg(REG_NOISE, noise);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return SAMPLE_BITS'($urandom_range(63) - 32);
            3: return SAMPLE_BITS'(1000 + $urandom_range(40));
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_noise();
        case ($urandom_range(4))
            0: return '0;
            1: return 31'h4000_0000;
            2: return 31'h7fff_ffff;
            3: return CFG_DATA_BITS'($urandom_range(100000));
            default: return CFG_DATA_BITS'($urandom());
        endcase
    endfunction

    initial
    begin : main
        int len, i;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes with default registers
        configure(1, 0);
        send_item(16'sh7fff, 0);
        send_item(16'sh8000, 0);
        send_item(0, 0);
        send_item(-1, 1);
        // Half width zero behaves as one
        configure(0, 31'h4000_0000);
        send_item(16'sh7fff, 0);
        send_item(16'sh8000, 0);
        send_item(16'sh7fff, 0);
        send_item(5, 0);
        send_item(16'sh8000, 1);
        // Array shorter than the half width, largest noise
        configure(15, 31'h7fff_ffff);
        send_item(100, 0);
        send_item(-20000, 0);
        send_item(32767, 1);
        // Single-sample array
        send_item(-32768, 1);
        // Lower the half width mid-array
        configure(4, 12345);
        for (i = 0; i < 6; i++) send_item(rand_sample(), 0);
        wait_idle();
        write_reg(REG_HALF_WIDTH, 1);
        send_item(rand_sample(), 0);
        send_item(rand_sample(), 1);

        // Random arrays under changing settings
        while (items_sent < 315)
        begin
            if (items_sent >= 240)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (items_sent >= 130)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 16;
            end
            if ($urandom_range(2) == 0)
                configure($urandom_range(15), rand_noise());
            if (items_sent >= 180 && items_sent < 200)
                hold_request = 400;
            len = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
            for (i = 0; i < len; i++)
                send_item(rand_sample(), i == len - 1);
        end
        wait_idle();
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #80ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> files.f
design/lswf_pkg.sv
design/lswf_div.sv
design/local_stats_wiener_filter.sv
sim/testbench.sv
